FILE: hw/rtl/hlt_pkg.sv
package hlt_pkg;

    // Table geometry and result cap
    localparam int MAX_CLIENTS_DEF = 16;
    localparam int MAX_RESULTS     = 16;

    // Field widths
    localparam int ID_W      = 16;
    localparam int TIME_W    = 32;
    localparam int TIMEOUT_W = 31;
    localparam int KIND_W    = 3;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(1000);

    // Operation codes
    localparam logic OP_HEARTBEAT = 1'b0;
    localparam logic OP_CHECK     = 1'b1;

    // Result kinds
    typedef logic [KIND_W-1:0] kind_t;
    localparam kind_t KIND_REFRESH = 3'd0;
    localparam kind_t KIND_ADD     = 3'd1;
    localparam kind_t KIND_FULL    = 3'd2;
    localparam kind_t KIND_OFFLINE = 3'd3;
    localparam kind_t KIND_NONE    = 3'd4;

endpackage

FILE: hw/rtl/heartbeat_liveness_table.sv
// Heartbeat liveness table.
// Command channel: an item (operation, client_id, now_ms) transfers on a rising
// edge with start high and busy low. Results leave on event_kind, reported_id
// and last_of_run, each valid for exactly one cycle while result_valid is high;
// the receiver cannot stall, so every strobed result is taken as it stands.
// The timeout register is written through cfg_we / cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
// Scan: both operations walk the slot store one slot per cycle through the
// registered read port of the client/time memory. In a check, offline results
// appear during the walk, the final one (last_of_run high) in the cycle busy
// drops. A heartbeat ends its walk at a matching slot, else walks them all.
// The next item may transfer in the cycle that the final result is shown.
// Reset: all slots invalid, timeout 1000 ms, no result pending. The memory
// needs no clearing pass, as its contents are only used behind a valid bit.
module heartbeat_liveness_table #(
    parameter int MAX_CLIENTS = hlt_pkg::MAX_CLIENTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           operation,
    input  logic [hlt_pkg::ID_W-1:0]       client_id,
    input  logic [hlt_pkg::TIME_W-1:0]     now_ms,
    input  logic                           cfg_we,
    input  logic [hlt_pkg::TIMEOUT_W-1:0]  cfg_wdata,
    output logic                           result_valid,
    output logic [hlt_pkg::KIND_W-1:0]     event_kind,
    output logic [hlt_pkg::ID_W-1:0]       reported_id,
    output logic                           last_of_run
);

    import hlt_pkg::*;

    localparam int IDX_W  = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_CLIENTS + 1);
    localparam int RES_W  = $clog2(MAX_RESULTS + 1);
    localparam int WORD_W = ID_W + TIME_W;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

    state_t                 state_reg, state_next;
    logic [TIMEOUT_W-1:0]   timeout_reg;
    logic [MAX_CLIENTS-1:0] valid_reg, valid_next;
    logic                   op_reg, op_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   ev_live_reg, ev_live_next;
    logic [IDX_W-1:0]       ev_idx_reg, ev_idx_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic                   hold_valid_reg, hold_valid_next;
    logic [ID_W-1:0]        hold_id_reg, hold_id_next;
    logic [RES_W-1:0]       res_cnt_reg, res_cnt_next;
    kind_t                  fin_kind_reg, fin_kind_next;
    logic                   res_valid_reg, res_valid_next;
    kind_t                  res_kind_reg, res_kind_next;
    logic [ID_W-1:0]        res_id_reg, res_id_next;
    logic                   res_last_reg, res_last_next;

    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_wr_addr;
    logic [WORD_W-1:0]      ram_wr_data;
    logic                   ram_rd_en;
    logic [WORD_W-1:0]      ram_rd_data;
    logic [ID_W-1:0]        ram_client;
    logic [TIME_W-1:0]      ram_seen;
    logic [TIME_W-1:0]      age;
    logic                   slot_on;
    logic                   last_slot;
    logic                   rd_more;
    logic                   done;
    logic [IDX_W-1:0]       free_sel;

    // Client id and last-seen time per slot
    hlt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_CLIENTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign ram_client = ram_rd_data[WORD_W-1:TIME_W];
    assign ram_seen   = ram_rd_data[TIME_W-1:0];
    assign age        = now_reg - ram_seen;
    assign slot_on    = valid_reg[ev_idx_reg];
    assign last_slot  = (ev_idx_reg == IDX_W'(MAX_CLIENTS - 1));
    assign rd_more    = (rd_idx_reg < CNT_W'(MAX_CLIENTS));
    assign free_sel   = free_found_reg ? free_idx_reg : ev_idx_reg;

    // Sequencer: issue one read per cycle, evaluate the slot read last cycle
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        now_next        = now_reg;
        rd_idx_next     = rd_idx_reg;
        ev_live_next    = ev_live_reg;
        ev_idx_next     = ev_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        hold_valid_next = hold_valid_reg;
        hold_id_next    = hold_id_reg;
        res_cnt_next    = res_cnt_reg;
        fin_kind_next   = fin_kind_reg;
        res_valid_next  = 1'b0;
        res_kind_next   = res_kind_reg;
        res_id_next     = res_id_reg;
        res_last_next   = res_last_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = ev_idx_reg;
        ram_wr_data     = {id_reg, now_reg};
        ram_rd_en       = 1'b0;
        done            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next         = operation;
                    id_next         = client_id;
                    now_next        = now_ms;
                    rd_idx_next     = '0;
                    ev_live_next    = 1'b0;
                    free_found_next = 1'b0;
                    hold_valid_next = 1'b0;
                    res_cnt_next    = '0;
                    state_next      = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Read stage
                ev_live_next = rd_more;
                ev_idx_next  = rd_idx_reg[IDX_W-1:0];
                if (rd_more)
                begin
                    ram_rd_en   = 1'b1;
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end

                // Evaluate stage
                if (ev_live_reg)
                begin
                    if (op_reg == OP_HEARTBEAT)
                    begin
                        if (slot_on && (ram_client == id_reg))
                        begin
                            ram_wr_en     = 1'b1;
                            ram_wr_addr   = ev_idx_reg;
                            fin_kind_next = KIND_REFRESH;
                            done          = 1'b1;
                        end
                        else
                        begin
                            if (!slot_on && !free_found_reg)
                            begin
                                free_found_next = 1'b1;
                                free_idx_next   = ev_idx_reg;
                            end
                            if (last_slot)
                            begin
                                done = 1'b1;
                                if (free_found_reg || !slot_on)
                                begin
                                    ram_wr_en            = 1'b1;
                                    ram_wr_addr          = free_sel;
                                    valid_next[free_sel] = 1'b1;
                                    fin_kind_next        = KIND_ADD;
                                end
                                else
                                begin
                                    fin_kind_next = KIND_FULL;
                                end
                            end
                        end
                    end
                    else
                    begin
                        if (slot_on && (age > {1'b0, timeout_reg}))
                        begin
                            valid_next[ev_idx_reg] = 1'b0;
                            // A held offline result is not the last one
                            if (hold_valid_reg)
                            begin
                                res_valid_next = 1'b1;
                                res_kind_next  = KIND_OFFLINE;
                                res_id_next    = hold_id_reg;
                                res_last_next  = 1'b0;
                            end
                            hold_valid_next = 1'b1;
                            hold_id_next    = ram_client;
                            res_cnt_next    = res_cnt_reg + RES_W'(1);
                            if (res_cnt_reg == RES_W'(MAX_RESULTS - 1))
                            begin
                                done = 1'b1;
                            end
                        end
                        if (last_slot)
                        begin
                            done = 1'b1;
                        end
                    end
                end

                if (done)
                begin
                    ev_live_next = 1'b0;
                    state_next   = S_FINISH;
                end
            end

            S_FINISH:
            begin
                // Final result of the item
                res_valid_next = 1'b1;
                res_last_next  = 1'b1;
                if (op_reg == OP_HEARTBEAT)
                begin
                    res_kind_next = fin_kind_reg;
                    res_id_next   = id_reg;
                end
                else if (hold_valid_reg)
                begin
                    res_kind_next = KIND_OFFLINE;
                    res_id_next   = hold_id_reg;
                end
                else
                begin
                    res_kind_next = KIND_NONE;
                    res_id_next   = '0;
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, valid bits and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            ev_live_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            res_cnt_reg    <= '0;
            rd_idx_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            ev_live_reg    <= ev_live_next;
            res_valid_reg  <= res_valid_next;
            free_found_reg <= free_found_next;
            hold_valid_reg <= hold_valid_next;
            res_cnt_reg    <= res_cnt_next;
            rd_idx_reg     <= rd_idx_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        now_reg      <= now_next;
        ev_idx_reg   <= ev_idx_next;
        free_idx_reg <= free_idx_next;
        hold_id_reg  <= hold_id_next;
        fin_kind_reg <= fin_kind_next;
        res_kind_reg <= res_kind_next;
        res_id_reg   <= res_id_next;
        res_last_reg <= res_last_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign event_kind   = res_kind_reg;
    assign reported_id  = res_id_reg;
    assign last_of_run  = res_last_reg;

    // Checks
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not raise busy");

    a_hb_single: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (event_kind == KIND_REFRESH || event_kind == KIND_ADD ||
                          event_kind == KIND_FULL)) |-> last_of_run)
        else $error("heartbeat result not marked last");

    a_none_form: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && event_kind == KIND_NONE) |-> (last_of_run && reported_id == '0))
        else $error("empty check result malformed");

    a_add_one: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) <= $countones($past(valid_reg)) + 1)
        else $error("more than one slot filled at once");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_of_run) |-> !busy)
        else $error("final result while still busy");

endmodule

FILE: hw/rtl/hlt_ram.sv
module hlt_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: test/tb_heartbeat_liveness_table.sv
`timescale 1ns / 100ps

module tb_heartbeat_liveness_table;

    import hlt_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int POOL_SIZE   = 20;

    // One result of the block
    typedef struct {
        kind_t            kind;
        logic [ID_W-1:0]  id;
        logic             last;
    } event_t;

    // One row of the directed table; reps > 1 sends consecutive ids
    typedef struct {
        logic              op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now;
        int                reps;
        bit                typed;
        kind_t             kind;
        logic [ID_W-1:0]   rid;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 operation;
    logic [ID_W-1:0]      client_id;
    logic [TIME_W-1:0]    now_ms;
    logic                 cfg_we;
    logic [TIMEOUT_W-1:0] cfg_wdata;
    logic                 result_valid;
    logic [KIND_W-1:0]    event_kind;
    logic [ID_W-1:0]      reported_id;
    logic                 last_of_run;

    // Predictor copy of the table and register
    bit                   live_valid [MAX_CLIENTS_DEF];
    logic [ID_W-1:0]      live_client [MAX_CLIENTS_DEF];
    logic [TIME_W-1:0]    live_seen [MAX_CLIENTS_DEF];
    logic [TIMEOUT_W-1:0] timeout_reg;

    event_t               pending_events [$];
    int                   errors;
    int                   stall_cycles;
    bit                   gaps_on;
    logic [TIME_W-1:0]    cur_time;
    logic [ID_W-1:0]      id_pool [POOL_SIZE];

    // Directed rows, timeout at its reset value of 1000 ms
    stim_row_t directed_rows [16] = '{
        '{OP_CHECK,     16'h0000, 32'h0000_0000, 1,  1'b1, KIND_NONE,    16'h0000},
        '{OP_HEARTBEAT, 16'h0000, 32'h0000_0000, 1,  1'b1, KIND_ADD,     16'h0000},
        '{OP_HEARTBEAT, 16'hFFFF, 32'hFFFF_FFFF, 1,  1'b1, KIND_ADD,     16'hFFFF},
        '{OP_HEARTBEAT, 16'h0000, 32'h0000_0005, 1,  1'b1, KIND_REFRESH, 16'h0000},
        // age exactly 1000 stays, wrapped age 1006 goes
        '{OP_CHECK,     16'hFFFF, 32'h0000_03ED, 1,  1'b0, KIND_NONE,    16'h0000},
        '{OP_HEARTBEAT, 16'h0100, 32'h0000_07D0, 15, 1'b0, KIND_NONE,    16'h0000},
        '{OP_HEARTBEAT, 16'h5A5A, 32'h0000_07D0, 1,  1'b1, KIND_FULL,    16'h5A5A},
        '{OP_HEARTBEAT, 16'h0107, 32'h0000_09C4, 1,  1'b1, KIND_REFRESH, 16'h0107},
        '{OP_CHECK,     16'h0000, 32'h0000_0BB8, 1,  1'b0, KIND_NONE,    16'h0000},
        '{OP_HEARTBEAT, 16'hA5A5, 32'h0000_0BB8, 1,  1'b1, KIND_ADD,     16'hA5A5},
        // whole table expires: the full run of results
        '{OP_CHECK,     16'h1111, 32'h0000_2710, 1,  1'b0, KIND_NONE,    16'h0000},
        '{OP_CHECK,     16'h0000, 32'h0000_2710, 1,  1'b1, KIND_NONE,    16'h0000},
        // time wraps past zero
        '{OP_HEARTBEAT, 16'h1234, 32'hFFFF_FF00, 1,  1'b1, KIND_ADD,     16'h1234},
        '{OP_CHECK,     16'h0000, 32'h0000_0100, 1,  1'b1, KIND_NONE,    16'h0000},
        '{OP_CHECK,     16'h0000, 32'h0000_02E8, 1,  1'b1, KIND_NONE,    16'h0000},
        '{OP_CHECK,     16'h0000, 32'h0000_02E9, 1,  1'b0, KIND_NONE,    16'h0000}
    };

    heartbeat_liveness_table u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .client_id    (client_id),
        .now_ms       (now_ms),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .event_kind   (event_kind),
        .reported_id  (reported_id),
        .last_of_run  (last_of_run)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Table update for one accepted item; appends the results it causes
    function automatic void liveness_events(input logic op, input logic [ID_W-1:0] id,
                                            input logic [TIME_W-1:0] now);
        int free_slot;
        int found;
        logic [TIME_W-1:0] age;
        free_slot = -1;
        found = 0;
        if (op == OP_HEARTBEAT)
        begin
            for (int i = 0; i < MAX_CLIENTS_DEF; i++)
            begin
                if (live_valid[i])
                begin
                    if (live_client[i] == id)
                    begin
                        live_seen[i] = now;
                        pending_events.push_back('{KIND_REFRESH, id, 1'b1});
                        return;
                    end
                end
                else if (free_slot < 0)
                    free_slot = i;
            end
            if (free_slot < 0)
                pending_events.push_back('{KIND_FULL, id, 1'b1});
            else
            begin
                live_valid[free_slot]  = 1'b1;
                live_client[free_slot] = id;
                live_seen[free_slot]   = now;
                pending_events.push_back('{KIND_ADD, id, 1'b1});
            end
        end
        else
        begin
            // walk every slot, capped at the result limit
            for (int i = 0; i < MAX_CLIENTS_DEF && found < MAX_RESULTS; i++)
            begin
                if (live_valid[i])
                begin
                    age = now - live_seen[i];
                    if (age > {1'b0, timeout_reg})
                    begin
                        live_valid[i] = 1'b0;
                        pending_events.push_back('{KIND_OFFLINE, live_client[i], 1'b0});
                        found++;
                    end
                end
            end
            if (found == 0)
                pending_events.push_back('{KIND_NONE, '0, 1'b1});
            else
                pending_events[pending_events.size()-1].last = 1'b1;
        end
    endfunction

    // Present one item and hold it until the transfer
    task automatic send_item(input logic op, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] now);
        @(negedge clk);
        if (gaps_on)
        begin
            while ($urandom_range(0, 99) < 20)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        start     <= 1'b1;
        operation <= op;
        client_id <= id;
        now_ms    <= now;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Timeout write once every result has drained
    task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
        @(negedge clk);
        start <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= value;
        timeout_reg  = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random traffic from a pool of clients on a drifting clock
    task automatic run_random_phase(input int n_items);
        logic              op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now;
        int                span;
        for (int i = 0; i < n_items; i++)
        begin
            span = (timeout_reg < 31'd20000) ? int'(timeout_reg) / 3 + 3 : 20000;
            if ($urandom_range(0, 99) < 3)
                cur_time += $urandom;
            else
                cur_time += $urandom_range(0, span);
            op  = ($urandom_range(0, 99) < 30) ? OP_CHECK : OP_HEARTBEAT;
            id  = ($urandom_range(0, 99) < 10) ? ID_W'($urandom_range(0, 65535))
                                                 : id_pool[$urandom_range(0, POOL_SIZE-1)];
            now = ($urandom_range(0, 99) < 5) ? TIME_W'($urandom) : cur_time;
            send_item(op, id, now);
            liveness_events(op, id, now);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        event_t want;
        if (rst_n && result_valid)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d id=%h last=%b",
                         $time, event_kind, reported_id, last_of_run);
                errors++;
            end
            else
            begin
                want = pending_events.pop_front();
                if (event_kind !== want.kind)
                begin
                    $display("%0t: event_kind expected %0d got %0d",
                             $time, want.kind, event_kind);
                    errors++;
                end
                if (reported_id !== want.id)
                begin
                    $display("%0t: reported_id expected %h got %h",
                             $time, want.id, reported_id);
                    errors++;
                end
                if (last_of_run !== want.last)
                begin
                    $display("%0t: last_of_run expected %b got %b",
                             $time, want.last, last_of_run);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer in either direction
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        logic [ID_W-1:0] hb_id;
        int n_before;
        logic [TIMEOUT_W-1:0] phase_timeouts [4];

        rst_n        = 1'b0;
        start        = 1'b0;
        operation    = OP_HEARTBEAT;
        client_id    = '0;
        now_ms       = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        errors       = 0;
        stall_cycles = 0;
        gaps_on      = 1'b1;
        timeout_reg  = TIMEOUT_RESET;
        foreach (live_valid[i])
            live_valid[i] = 1'b0;
        foreach (id_pool[i])
            id_pool[i] = ID_W'($urandom_range(0, 65535));
        cur_time = $urandom;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed table
        foreach (directed_rows[r])
        begin
            for (int k = 0; k < directed_rows[r].reps; k++)
            begin
                hb_id = directed_rows[r].id + ID_W'(k);
                send_item(directed_rows[r].op, hb_id, directed_rows[r].now);
                n_before = pending_events.size();
                liveness_events(directed_rows[r].op, hb_id, directed_rows[r].now);
                if (directed_rows[r].typed)
                begin
                    while (pending_events.size() > n_before)
                        void'(pending_events.pop_back());
                    pending_events.push_back('{directed_rows[r].kind,
                                               directed_rows[r].rid, 1'b1});
                end
            end
        end

        // Random phases, each under its own timeout; the second runs without gaps
        phase_timeouts[0] = '0;
        phase_timeouts[1] = 31'h7FFF_FFFF;
        phase_timeouts[2] = TIMEOUT_W'($urandom_range(50, 3000));
        phase_timeouts[3] = TIMEOUT_W'($urandom);
        for (int p = 0; p < 4; p++)
        begin
            write_timeout(phase_timeouts[p]);
            gaps_on = (p != 1);
            run_random_phase(100);
        end

        // Drain
        @(negedge clk);
        start <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (MAX_CLIENTS_DEF + 4) @(posedge clk);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/hlt_pkg.sv
hw/rtl/hlt_ram.sv
hw/rtl/heartbeat_liveness_table.sv
test/tb_heartbeat_liveness_table.sv
